@@ sv/lfcrc_pkg.sv @@
package lfcrc_pkg;

  localparam int unsigned HEADER_BYTES = 6;

  localparam int unsigned POS_W   = 17;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned IDLE_W  = 32;

  // header bytes carrying the big-endian body length
  localparam logic [POS_W-1:0] LEN_HI_POS = 17'd4;
  localparam logic [POS_W-1:0] LEN_LO_POS = 17'd5;

  localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;
  localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 32'd1000000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_CRCERR  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Modbus CRC-16, reflected, one byte per call
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0]       b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ sv/length_framed_crc16_receiver.sv @@
// Length-framed receiver with Modbus CRC-16 check. Each accepted word is either a
// received byte (op 0) or one time tick (op 1). A frame is six header bytes, a body
// whose length is header bytes 4 and 5 (big-endian), then two check bytes, CRC low
// byte first. Every byte is echoed with its position, frame_end and status on the
// last byte give ok or crc mismatch; ticks mid-frame count idle time and abort the
// frame with a timeout result once the count reaches idle_timeout_ticks. The block
// takes one word per cycle; its result appears in the output register on the next
// cycle. Input is stalled only while that register holds a result that is itself
// stalled. The timeout register is written through cfg_write_en/cfg_data.
module length_framed_crc16_receiver
  import lfcrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              cfg_write_en,
  input  logic [IDLE_W-1:0] cfg_data,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [7:0]        data_byte,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        byte_out,
  output logic [POS_W-1:0]  byte_index,
  output logic              frame_end,
  output logic [1:0]        status,
  output logic [CRC_W-1:0]  computed_crc
);

  logic [IDLE_W-1:0] idle_timeout_ticks;
  logic [POS_W-1:0]  position;
  logic [LEN_W-1:0]  body_length;
  logic [CRC_W-1:0]  crc_register;
  logic [7:0]        first_check_byte;
  logic [IDLE_W-1:0] idle_count;

  logic [POS_W-1:0]  position_next;
  logic [LEN_W-1:0]  body_length_next;
  logic [CRC_W-1:0]  crc_register_next;
  logic [7:0]        first_check_byte_next;
  logic [IDLE_W-1:0] idle_count_next;

  logic              res_valid;
  logic [7:0]        res_byte;
  logic              res_end;
  logic [1:0]        res_status;
  logic [CRC_W-1:0]  res_crc;

  logic              accept;
  logic [POS_W-1:0]  total;
  logic [CRC_W-1:0]  crc_upd;
  logic [IDLE_W-1:0] idle_inc;
  logic              clear;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign total    = POS_W'(HEADER_BYTES) + {1'b0, body_length};
  assign crc_upd  = crc_byte(crc_register, data_byte);
  assign idle_inc = (idle_count == '1) ? idle_count : idle_count + 1'b1;

  always_comb begin
    position_next         = position;
    body_length_next      = body_length;
    crc_register_next     = crc_register;
    first_check_byte_next = first_check_byte;
    idle_count_next       = idle_count;
    res_valid             = 1'b0;
    res_byte              = data_byte;
    res_end               = 1'b0;
    res_status            = ST_BUSY;
    res_crc               = crc_register;
    clear                 = 1'b0;

    if (op == OP_TICK) begin
      res_byte = 8'h00;
      if (position != '0) begin
        idle_count_next = idle_inc;
        if (idle_inc >= idle_timeout_ticks) begin
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_status = ST_TIMEOUT;
          clear      = 1'b1;
        end
      end
    end else begin
      res_valid       = 1'b1;
      idle_count_next = '0;
      position_next   = position + 1'b1;
      if (position < POS_W'(HEADER_BYTES)) begin
        if (position == LEN_HI_POS) begin
          body_length_next = {data_byte, body_length[7:0]};
        end else if (position == LEN_LO_POS) begin
          body_length_next = {body_length[15:8], data_byte};
        end
        crc_register_next = crc_upd;
        res_crc           = crc_upd;
      end else if (position < total) begin
        crc_register_next = crc_upd;
        res_crc           = crc_upd;
      end else if (position == total) begin
        first_check_byte_next = data_byte;
      end else begin
        res_end = 1'b1;
        clear   = 1'b1;
        if (first_check_byte == crc_register[7:0] && data_byte == crc_register[15:8]) begin
          res_status = ST_OK;
        end else begin
          res_status = ST_CRCERR;
        end
      end
    end

    if (clear) begin
      position_next         = '0;
      body_length_next      = '0;
      crc_register_next     = CRC_INIT;
      first_check_byte_next = '0;
      idle_count_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ticks <= TIMEOUT_RESET;
      position           <= '0;
      body_length        <= '0;
      crc_register       <= CRC_INIT;
      first_check_byte   <= '0;
      idle_count         <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        idle_timeout_ticks <= cfg_data;
      end
      if (accept) begin
        position         <= position_next;
        body_length      <= body_length_next;
        crc_register     <= crc_register_next;
        first_check_byte <= first_check_byte_next;
        idle_count       <= idle_count_next;
      end
      // result register: load on a word with a result, else drain when taken
      if (accept && res_valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      byte_out     <= res_byte;
      byte_index   <= position;
      frame_end    <= res_end;
      status       <= res_status;
      computed_crc <= res_crc;
    end
  end

endmodule
